// File: sv/escape_sequence_decoder_top_macros.svh
// Assertion macros for the escape sequence decoder.
`ifndef ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ESD_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("esd: check failed");
`define ESD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esd: implication failed");
`else
`define ESD_ASSERT(label, cond)
`define ESD_ASSERT_IMP(label, ante, cons)
`endif

`endif

// File: sv/esd_pkg.sv
// Shared types, character codes and helpers of the escape sequence decoder.
`default_nettype none
package esd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_HT  = 8'd9;
  localparam logic [7:0] CODE_VT  = 8'd11;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_BEL = 8'd7;

  typedef enum logic [2:0] {
    M_NORMAL,
    M_ESC,
    M_OCT,
    M_HEX0,
    M_HEX1
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       bad_escape;
    logic       out_last;
  } result_t;

  // One queue entry holds every result of one input item.
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_7);
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 give its value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      return {1'b1, d[3:0]};
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 8'd10;
      return {1'b1, d[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage
`default_nettype wire

// File: sv/escape_sequence_decoder_top.sv
// Each character's entry goes into the queue and from there into the output register.
// Throughput: one character per cycle while full is low; a character with two
// results takes two pops. The four-entry queue between front end and output stage
// absorbs result stalls. Reset (rst, synchronous, active high) returns the decoder to
// plain text with no error and empties the queue and the output register.
`default_nettype none
`include "escape_sequence_decoder_top_macros.svh"
module escape_sequence_decoder_top
  import esd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  item_t     item,
  output logic      empty,
  input  wire logic pop,
  output result_t   result
);

  logic   accept;
  logic   qwr, qpop;
  entry_t wr_entry, rd_entry;
  qstat_t qstat;

  assign full   = qstat.full;
  assign accept = push && !qstat.full;

  esd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .wr       (qwr),
    .wr_entry (wr_entry)
  );

  esd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (qwr),
    .wr_entry (wr_entry),
    .rd       (qpop),
    .rd_entry (rd_entry),
    .stat     (qstat)
  );

  esd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .entry  (rd_entry),
    .qstat  (qstat),
    .qpop   (qpop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  `ESD_ASSERT(a_no_pop_empty_queue, !(qpop && qstat.empty))
  `ESD_ASSERT(a_no_write_full_queue, !(qwr && qstat.full))
  `ESD_ASSERT_IMP(a_marker_is_last, !empty && !result.has_byte, result.out_last)
  `ESD_ASSERT_IMP(a_marker_zero, !empty && !result.has_byte, result.out_byte == 8'd0)

endmodule
`default_nettype wire

// File: sv/esd_front.sv
// Front end: takes raw characters, runs the escape state machine, forms queue entries.
`default_nettype none
module esd_front
  import esd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   accept,
  input  item_t       item,
  output logic        wr,
  output entry_t      wr_entry
);

  mode_t      mode, mode_next;
  logic [8:0] digit_value, digit_value_next;
  logic [1:0] digit_count, digit_count_next;
  logic       error_seen, error_seen_next;

  logic [7:0] rb [2];
  logic       rh [2];
  logic [1:0] n;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_NORMAL;
      digit_value <= 9'd0;
      digit_count <= 2'd0;
      error_seen  <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      digit_value <= digit_value_next;
      digit_count <= digit_count_next;
      error_seen  <= error_seen_next;
    end
  end

  always_comb begin
    logic [7:0] c;
    logic [4:0] hv;
    logic       plain;
    mode_t      m;
    c  = item.in_byte;
    hv = hex_val(c);
    m                = M_NORMAL;
    digit_value_next = digit_value;
    digit_count_next = digit_count;
    error_seen_next  = error_seen;
    n     = 2'd0;
    rb[0] = 8'd0;
    rb[1] = 8'd0;
    rh[0] = 1'b0;
    rh[1] = 1'b0;
    plain = 1'b0;

    case (mode)
      M_ESC: begin
        case (c)
          CH_N: begin rb[0] = CODE_LF;  rh[0] = 1'b1; n = 2'd1; end
          CH_T: begin rb[0] = CODE_HT;  rh[0] = 1'b1; n = 2'd1; end
          CH_V: begin rb[0] = CODE_VT;  rh[0] = 1'b1; n = 2'd1; end
          CH_B: begin rb[0] = CODE_BS;  rh[0] = 1'b1; n = 2'd1; end
          CH_R: begin rb[0] = CODE_CR;  rh[0] = 1'b1; n = 2'd1; end
          CH_F: begin rb[0] = CODE_FF;  rh[0] = 1'b1; n = 2'd1; end
          CH_A: begin rb[0] = CODE_BEL; rh[0] = 1'b1; n = 2'd1; end
          CH_BSLASH, CH_QMARK, CH_SQUOTE, CH_DQUOTE: begin
            rb[0] = c;
            rh[0] = 1'b1;
            n     = 2'd1;
          end
          CH_X: begin
            m                = M_HEX0;
            digit_value_next = 9'd0;
          end
          default: begin
            if (is_oct(c)) begin
              m                = M_OCT;
              digit_value_next = {6'd0, c[2:0]};
              digit_count_next = 2'd1;
            end else begin
              error_seen_next = 1'b1;
            end
          end
        endcase
      end
      M_OCT: begin
        if (is_oct(c)) begin
          digit_value_next = {digit_value[5:0], c[2:0]};
          digit_count_next = digit_count + 2'd1;
          m                = M_OCT;
          // third digit closes the run
          if (digit_count == 2'd2) begin
            rb[0] = digit_value_next[7:0];
            rh[0] = 1'b1;
            n     = 2'd1;
            m                = M_NORMAL;
            digit_count_next = 2'd0;
            digit_value_next = 9'd0;
          end
        end else begin
          rb[0] = digit_value[7:0];
          rh[0] = 1'b1;
          n     = 2'd1;
          digit_count_next = 2'd0;
          digit_value_next = 9'd0;
          plain = 1'b1;
        end
      end
      M_HEX0: begin
        if (hv[4]) begin
          digit_value_next = {5'd0, hv[3:0]};
          m                = M_HEX1;
        end else begin
          error_seen_next = 1'b1;
          plain = 1'b1;
        end
      end
      M_HEX1: begin
        if (hv[4]) begin
          rb[0] = {digit_value[3:0], hv[3:0]};
        end else begin
          rb[0] = digit_value[7:0];
          plain = 1'b1;
        end
        rh[0] = 1'b1;
        n     = 2'd1;
        digit_value_next = 9'd0;
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    // ordinary text, also the ending non-digit of a run; a backslash starts an escape
    if (plain) begin
      if (c == CH_BSLASH) begin
        m = M_ESC;
      end else begin
        rb[n[0]] = c;
        rh[n[0]] = 1'b1;
        n = n + 2'd1;
      end
    end

    if (item.in_last) begin
      if (m == M_OCT || m == M_HEX1) begin
        rb[n[0]] = digit_value_next[7:0];
        rh[n[0]] = 1'b1;
        n = n + 2'd1;
      end else if (m == M_ESC || m == M_HEX0) begin
        error_seen_next = 1'b1;
      end
      // end marker when nothing was decoded
      if (n == 2'd0) begin
        n = 2'd1;
      end
    end

    wr = accept && (n != 2'd0);
    wr_entry.r0.out_byte   = rb[0];
    wr_entry.r0.has_byte   = rh[0];
    wr_entry.r0.bad_escape = error_seen_next;
    wr_entry.r0.out_last   = item.in_last && (n == 2'd1);
    wr_entry.r1.out_byte   = rb[1];
    wr_entry.r1.has_byte   = rh[1];
    wr_entry.r1.bad_escape = error_seen_next;
    wr_entry.r1.out_last   = item.in_last;
    wr_entry.two           = (n == 2'd2);

    mode_next = m;
    // string done: back to reset values
    if (item.in_last) begin
      mode_next        = M_NORMAL;
      digit_value_next = 9'd0;
      digit_count_next = 2'd0;
      error_seen_next  = 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: sv/esd_queue.sv
// Short entry queue between the front end and the output stage.
`default_nettype none
module esd_queue
  import esd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  entry_t    wr_entry,
  input  wire logic rd,
  output entry_t    rd_entry,
  output qstat_t    stat
);

  entry_t         mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
  end

  assign rd_entry   = mem[rptr];
  assign stat.full  = (count == (QAW+1)'(QDEPTH));
  assign stat.empty = (count == '0);

endmodule
`default_nettype wire

// File: sv/esd_back.sv
// Output stage: unpacks queue entries into single results behind an output register.
`default_nettype none
module esd_back
  import esd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  entry_t    entry,
  input  qstat_t    qstat,
  output logic      qpop,
  input  wire logic pop,
  output logic      empty,
  output result_t   result
);

  logic    ov, pv;
  result_t held;
  logic    room;

  assign room = !ov || pop;
  assign qpop = room && !pv && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      pv <= 1'b0;
    end else if (room) begin
      if (pv) begin
        ov <= 1'b1;
        pv <= 1'b0;
      end else if (!qstat.empty) begin
        ov <= 1'b1;
        pv <= entry.two;
      end else begin
        ov <= 1'b0;
      end
    end
  end

  // advance the payload with the valid bits
  always_ff @(posedge clk) begin
    if (room) begin
      if (pv) begin
        result <= held;
      end else if (!qstat.empty) begin
        result <= entry.r0;
        held   <= entry.r1;
      end
    end
  end

  assign empty = !ov;

endmodule
`default_nettype wire
